// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define PLE_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ple assertion failed");

// Clocked property that also holds during reset.
`define PLE_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) (prop)) \
      else $error("ple assertion failed");

`endif

// ===== rtl/ple_pkg.sv =====
package ple_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // position field in the cell control word, wide enough for the largest list
   localparam int POS_W    = 11;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_INSERT_AT  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_REMOVE_AT  = 3'd5,
      OP_UPDATE_AT  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_POS   = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_WRITE
   } cell_cmd_type;

   typedef enum logic {
      S_IDLE,
      S_COLLECT
   } fsm_state_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic [POS_W-1:0]    pos;
      logic [DATA_W-1:0]   value;
      logic                capture;
   } cell_ctrl_type;

endpackage

// ===== rtl/ple_if.sv =====
interface ple_req_if #(parameter int IDX_W = ple_pkg::CNT_W);
   logic                              valid;
   logic                              ready;
   logic [ple_pkg::OP_W-1:0]          op;
   logic signed [ple_pkg::DATA_W-1:0] value_in;
   logic [IDX_W-1:0]                  index;
   logic                              clear_all;

   modport source (output valid, output op, output value_in, output index,
                   output clear_all, input ready);
   modport sink   (input valid, input op, input value_in, input index,
                   input clear_all, output ready);
endinterface

interface ple_rsp_if #(parameter int CNT_W = ple_pkg::CNT_W);
   logic                              valid;
   logic                              ready;
   logic [ple_pkg::STATUS_W-1:0]      status;
   logic signed [ple_pkg::DATA_W-1:0] value_out;
   logic [CNT_W-1:0]                  count;

   modport source (output valid, output status, output value_out, output count,
                   input ready);
   modport sink   (input valid, input status, input value_out, input count,
                   output ready);
endinterface

// ===== rtl/ple_cell.sv =====
module ple_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  ple_pkg::cell_ctrl_type        ctrl,
   input  logic [ple_pkg::DATA_W-1:0]    left_data,
   input  logic [ple_pkg::DATA_W-1:0]    right_data,
   output logic [ple_pkg::DATA_W-1:0]    data,
   output logic [ple_pkg::DATA_W-1:0]    tap
);

   localparam logic [ple_pkg::POS_W-1:0] MY_POS = ple_pkg::POS_W'(CELL_IDX);

   logic [ple_pkg::DATA_W-1:0] value_ff, value_in;
   logic [ple_pkg::DATA_W-1:0] tap_ff, tap_in;
   logic                       hit, behind;

   assign hit    = (ctrl.pos == MY_POS);
   assign behind = (MY_POS > ctrl.pos);

   always_comb begin
      value_in = value_ff;
      case (ctrl.cmd)
         ple_pkg::CELL_INSERT: begin
            if (hit)
               value_in = ctrl.value;
            else if (behind)
               value_in = left_data;
         end
         ple_pkg::CELL_REMOVE: begin
            if (hit || behind)
               value_in = right_data;
         end
         ple_pkg::CELL_WRITE: begin
            if (hit)
               value_in = ctrl.value;
         end
         default: value_in = value_ff;
      endcase
   end

   // tap holds the removed element for the collect cycle, zero elsewhere
   always_comb begin
      tap_in = tap_ff;
      if (ctrl.capture)
         tap_in = (ctrl.cmd == ple_pkg::CELL_REMOVE && hit) ? value_ff : '0;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      tap_ff   <= tap_in;
   end

   assign data = value_ff;
   assign tap  = tap_ff;

endmodule

// ===== rtl/ple_ctrl.sv =====
module ple_ctrl #(
   parameter int CAPACITY = ple_pkg::CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   ple_req_if.sink                       req_chan,
   ple_rsp_if.source                     rsp_chan,
   input  logic [ple_pkg::DATA_W-1:0]    tap_or,
   output ple_pkg::cell_ctrl_type        cell_ctrl
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   ple_pkg::fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   ple_pkg::status_type    st_ff, st_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [ple_pkg::DATA_W-1:0]        rsp_value_ff;
   logic [CNT_W-1:0]                  rsp_count_ff;

   ple_pkg::op_type        op_sel;
   ple_pkg::cell_cmd_type  cmd_dec;
   logic [CNT_W-1:0]       idx, ins_pos, rem_pos, pos_dec, count_dec;
   ple_pkg::status_type    st_dec;
   logic                   accept, load_rsp;

   assign op_sel = ple_pkg::op_type'(req_chan.op);
   assign idx    = CNT_W'(req_chan.index);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      case (op_sel)
         ple_pkg::OP_PUSH_FRONT: ins_pos = '0;
         ple_pkg::OP_PUSH_BACK:  ins_pos = count_ff;
         default:                ins_pos = idx;
      endcase
      case (op_sel)
         ple_pkg::OP_POP_FRONT: rem_pos = '0;
         ple_pkg::OP_POP_BACK:  rem_pos = count_ff - 1'b1;
         default:               rem_pos = idx;
      endcase
   end

   always_comb begin
      st_dec    = ple_pkg::ST_OK;
      cmd_dec   = ple_pkg::CELL_HOLD;
      pos_dec   = '0;
      count_dec = count_ff;
      if (req_chan.clear_all) begin
         st_dec    = (count_ff == '0) ? ple_pkg::ST_EMPTY : ple_pkg::ST_OK;
         count_dec = '0;
      end else begin
         case (op_sel)
            ple_pkg::OP_PUSH_FRONT, ple_pkg::OP_PUSH_BACK, ple_pkg::OP_INSERT_AT: begin
               if (ins_pos > count_ff)
                  st_dec = ple_pkg::ST_POS;
               else if (count_ff >= CAP_CNT)
                  st_dec = ple_pkg::ST_FULL;
               else begin
                  cmd_dec   = ple_pkg::CELL_INSERT;
                  pos_dec   = ins_pos;
                  count_dec = count_ff + 1'b1;
               end
            end
            ple_pkg::OP_POP_FRONT, ple_pkg::OP_POP_BACK, ple_pkg::OP_REMOVE_AT: begin
               if (count_ff == '0)
                  st_dec = ple_pkg::ST_EMPTY;
               else if (rem_pos >= count_ff)
                  st_dec = ple_pkg::ST_POS;
               else begin
                  cmd_dec   = ple_pkg::CELL_REMOVE;
                  pos_dec   = rem_pos;
                  count_dec = count_ff - 1'b1;
               end
            end
            ple_pkg::OP_UPDATE_AT: begin
               if (idx >= count_ff)
                  st_dec = ple_pkg::ST_POS;
               else begin
                  cmd_dec = ple_pkg::CELL_WRITE;
                  pos_dec = idx;
               end
            end
            default: st_dec = ple_pkg::ST_OK;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ple_pkg::S_IDLE:    if (accept) state_in = ple_pkg::S_COLLECT;
         ple_pkg::S_COLLECT: if (load_rsp) state_in = ple_pkg::S_IDLE;
         default:            state_in = ple_pkg::S_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_chan.ready = 1'b0;
      load_rsp       = 1'b0;
      case (state_ff)
         ple_pkg::S_IDLE:    req_chan.ready = 1'b1;
         ple_pkg::S_COLLECT: load_rsp = !rsp_valid_ff || rsp_chan.ready;
         default:            req_chan.ready = 1'b0;
      endcase
   end

   always_comb begin
      cell_ctrl.cmd     = accept ? cmd_dec : ple_pkg::CELL_HOLD;
      cell_ctrl.pos     = ple_pkg::POS_W'(pos_dec);
      cell_ctrl.value   = req_chan.value_in;
      cell_ctrl.capture = accept;
   end

   assign count_in = accept ? count_dec : count_ff;
   assign st_in    = accept ? st_dec : st_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (load_rsp) begin
         rsp_status_ff <= st_ff;
         rsp_value_ff  <= tap_or;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.value_out = rsp_value_ff;
   assign rsp_chan.count     = rsp_count_ff;

endmodule

// ===== rtl/positional_list_engine_top.sv =====
// Bounded ordered list of signed 32-bit values, kept packed from the front.
// req_chan (sink): op, value_in, index, clear_all; a transaction completes
// when valid and ready are both high. rsp_chan (source): status, value_out
// and the count after the request, one response per request.
// Storage is a row of CAPACITY cells. On an insert every cell behind the
// position takes its left neighbor's value, on a remove every cell from it on
// its right neighbor's, all in the same cycle, so no operation depends on the
// list length. The request is decoded and the cells updated at the accepting
// edge; the collect state then ORs the cell taps into the response register.
// A new request is taken only after the execute/collect pair of the last one.
// The response register decouples the two sides: a request may be accepted
// while the previous response still waits. If the receiver stalls longer,
// the finished result waits in the collect state and req_chan.ready stays
// low until it can move into the response register.
// Reset (synchronous, active high) empties the list and drops any pending
// response; cell contents are left as they are and never read before written.
module positional_list_engine_top #(
   parameter int CAPACITY = ple_pkg::CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_chan,
   ple_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   ple_pkg::cell_ctrl_type       cell_ctrl;
   logic [ple_pkg::DATA_W-1:0]   cell_data [CAPACITY];
   logic [ple_pkg::DATA_W-1:0]   cell_tap  [CAPACITY];
   logic [ple_pkg::DATA_W-1:0]   tap_or;

   ple_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .tap_or    (tap_or),
      .cell_ctrl (cell_ctrl)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ple_pkg::DATA_W-1:0] left_data, right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      ple_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .tap        (cell_tap[i])
      );
   end

   // at most one tap is nonzero
   always_comb begin
      tap_or = '0;
      for (int i = 0; i < CAPACITY; i++)
         tap_or = tap_or | cell_tap[i];
   end

endmodule

// ===== rtl/ple_checker.sv =====
`include "assert_macros.svh"

module ple_checker #(
   parameter int CAPACITY = ple_pkg::CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ple_pkg::STATUS_W-1:0]  rsp_status,
   input logic [ple_pkg::DATA_W-1:0]    rsp_value_out,
   input logic [CNT_W-1:0]              rsp_count
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // a stalled response holds
   `PLE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value_out) && $stable(rsp_count))

   // the list never grows past its capacity; valid is unknown before the first reset edge
   `PLE_ASSERT_ALWAYS(a_count_bound, clock, (rsp_valid !== 1'b1) || rsp_count <= CAP_CNT)

   // a full response only comes from a full list
   `PLE_ASSERT(a_full_count, clock, reset, rsp_valid && rsp_status == ple_pkg::ST_FULL |-> rsp_count == CAP_CNT)

   // nothing is taken out on a failed request
   `PLE_ASSERT(a_value_zero, clock, reset, rsp_valid && rsp_status != ple_pkg::ST_OK |-> rsp_value_out == '0)

   // an accepted request takes ready low while the block collects its result
   `PLE_ASSERT(a_spacing, clock, reset, req_valid && req_ready |=> !req_ready)

endmodule

bind positional_list_engine_top ple_checker #(
   .CAPACITY (CAPACITY)
) u_ple_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_value_out (rsp_chan.value_out),
   .rsp_count     (rsp_chan.count)
);

// ===== tb/positional_list_engine_top_test.sv =====
module positional_list_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 1050;
   localparam int STALL_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 8;
   localparam int INDEX_MAX    = 127;

   // not decoded, must leave the list alone
   localparam logic [ple_pkg::OP_W-1:0] OP_SPARE = 3'd7;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_FILL} mix_type;
   typedef enum logic [1:0] {RCV_OPEN, RCV_THROTTLE, RCV_COIN, RCV_CHOKE} rcv_type;

   typedef struct {
      logic [ple_pkg::OP_W-1:0]          op;
      logic signed [ple_pkg::DATA_W-1:0] value;
      logic [ple_pkg::CNT_W-1:0]         index;
      logic                              clear;
      bit                                drain_first;
   } list_req_type;

   typedef struct {
      ple_pkg::status_type               status;
      logic signed [ple_pkg::DATA_W-1:0] taken;
      logic [ple_pkg::CNT_W-1:0]         count;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ple_req_if req_chan ();
   ple_rsp_if rsp_chan ();

   positional_list_engine_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   logic signed [ple_pkg::DATA_W-1:0] list_image[$];   // expected list contents, front at 0
   list_req_type                      pending_reqs[$];
   list_rsp_type                      predicted_replies[$];
   logic                              drained;
   int                                mismatches = 0;

   // ---------------------------------------------------------------- prediction

   function automatic ple_pkg::status_type place_value(int pos,
                                                       logic signed [ple_pkg::DATA_W-1:0] v);
      if (pos > list_image.size()) return ple_pkg::ST_POS;
      if (list_image.size() >= ple_pkg::CAPACITY) return ple_pkg::ST_FULL;
      list_image.insert(pos, v);
      return ple_pkg::ST_OK;
   endfunction

   function automatic ple_pkg::status_type take_value(int pos,
                                                      output logic signed [ple_pkg::DATA_W-1:0] v);
      v = '0;
      if (list_image.size() == 0) return ple_pkg::ST_EMPTY;
      if (pos >= list_image.size()) return ple_pkg::ST_POS;
      v = list_image[pos];
      list_image.delete(pos);
      return ple_pkg::ST_OK;
   endfunction

   function automatic list_rsp_type apply_list_op(list_req_type r);
      list_rsp_type res;
      int           n;
      n          = list_image.size();
      res.status = ple_pkg::ST_OK;
      res.taken  = '0;
      if (r.clear) begin
         if (n == 0) res.status = ple_pkg::ST_EMPTY;
         list_image.delete();
      end else begin
         case (r.op)
            ple_pkg::OP_PUSH_FRONT: res.status = place_value(0, r.value);
            ple_pkg::OP_PUSH_BACK:  res.status = place_value(n, r.value);
            ple_pkg::OP_INSERT_AT:  res.status = place_value(int'(r.index), r.value);
            ple_pkg::OP_POP_FRONT:  res.status = take_value(0, res.taken);
            ple_pkg::OP_POP_BACK:   res.status = take_value((n == 0) ? 0 : n - 1, res.taken);
            ple_pkg::OP_REMOVE_AT:  res.status = take_value(int'(r.index), res.taken);
            ple_pkg::OP_UPDATE_AT: begin
               if (int'(r.index) >= n) res.status = ple_pkg::ST_POS;
               else list_image[r.index] = r.value;
            end
            default: ;
         endcase
      end
      if (res.status != ple_pkg::ST_OK) res.taken = '0;
      res.count = ple_pkg::CNT_W'(list_image.size());
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus plan

   // the plan runs the list image forward so indexes can track the real length
   function automatic void plan_req(logic [ple_pkg::OP_W-1:0] op,
                                    logic signed [ple_pkg::DATA_W-1:0] value,
                                    int index, logic clear, bit drain_first);
      list_req_type r;
      r.op          = op;
      r.value       = value;
      r.index       = ple_pkg::CNT_W'(index);
      r.clear       = clear;
      r.drain_first = drain_first;
      pending_reqs.push_back(r);
      void'(apply_list_op(r));
   endfunction

   function automatic void plan_random_req(mix_type mix, bit drain_first);
      logic [ple_pkg::OP_W-1:0]          op;
      logic signed [ple_pkg::DATA_W-1:0] value;
      logic                              clear;
      int                                n;
      int                                grow_pct;
      int                                pick;
      int                                index;
      n = list_image.size();
      case (mix)
         MIX_GROW:   grow_pct = 80;
         MIX_SHRINK: grow_pct = 20;
         MIX_FILL:   grow_pct = 97;
         default:    grow_pct = 50;
      endcase
      if ($urandom_range(0, 99) < 3)
         op = OP_SPARE;
      else if ($urandom_range(0, 99) < grow_pct)
         op = ple_pkg::OP_W'($urandom_range(ple_pkg::OP_PUSH_FRONT, ple_pkg::OP_INSERT_AT));
      else
         op = ple_pkg::OP_W'($urandom_range(ple_pkg::OP_POP_FRONT, ple_pkg::OP_UPDATE_AT));
      clear = (mix != MIX_FILL) && ($urandom_range(0, 99) < 2);
      pick  = $urandom_range(0, 19);
      if (pick == 0) index = $urandom_range(0, INDEX_MAX);
      else if (pick < 4) index = n;
      else index = $urandom_range(0, n);
      case ($urandom_range(0, 15))
         0:       value = 32'sh7fff_ffff;
         1:       value = 32'sh8000_0000;
         2:       value = '0;
         default: value = $urandom();
      endcase
      plan_req(op, value, index, clear, drain_first);
   endfunction

   initial begin
      mix_type mix;
      int      len;
      bit      drain;

      req_chan.valid     = 1'b0;
      req_chan.op        = ple_pkg::OP_PUSH_FRONT;
      req_chan.value_in  = '0;
      req_chan.index     = '0;
      req_chan.clear_all = 1'b0;
      rsp_chan.ready     = 1'b0;
      drained            = 1'b1;

      // clear, removes, update, an out-of-range insert and the spare op on an empty list
      plan_req(ple_pkg::OP_PUSH_FRONT, '0, 0, 1'b1, 0);
      plan_req(ple_pkg::OP_POP_FRONT,  '0, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_POP_BACK,   '0, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_REMOVE_AT,  '0, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_UPDATE_AT,  32'sd5, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_INSERT_AT,  32'sd6, 1, 1'b0, 0);
      plan_req(OP_SPARE,               32'sd7, 0, 1'b0, 0);
      // build up, inserting at the count appends
      plan_req(ple_pkg::OP_INSERT_AT,  32'sh7fff_ffff, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_PUSH_BACK,  32'sh8000_0000, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_PUSH_FRONT, '0, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_PUSH_BACK,  -32'sd1, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_INSERT_AT,  32'sh5555_5555, 4, 1'b0, 0);
      plan_req(ple_pkg::OP_INSERT_AT,  32'shaaaa_aaaa, 2, 1'b0, 0);
      plan_req(ple_pkg::OP_INSERT_AT,  32'sd1, 7, 1'b0, 0);
      plan_req(ple_pkg::OP_UPDATE_AT,  32'sd12345, 3, 1'b0, 0);
      plan_req(ple_pkg::OP_UPDATE_AT,  32'sd2, 6, 1'b0, 0);
      // index equal to the count is out of range for remove
      plan_req(ple_pkg::OP_REMOVE_AT,  '0, 6, 1'b0, 0);
      plan_req(ple_pkg::OP_REMOVE_AT,  '0, 2, 1'b0, 0);
      plan_req(ple_pkg::OP_POP_BACK,   '0, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_POP_FRONT,  '0, 0, 1'b0, 0);
      plan_req(ple_pkg::OP_REMOVE_AT,  '1, INDEX_MAX, 1'b0, 0);
      plan_req(OP_SPARE,               '1, INDEX_MAX, 1'b0, 0);
      plan_req(OP_SPARE,               '0, 0, 1'b1, 1);

      while (pending_reqs.size() < 23 + RANDOM_ITEMS) begin
         mix   = mix_type'($urandom_range(MIX_GROW, MIX_FILL));
         len   = $urandom_range(10, 60);
         drain = ($urandom_range(0, 3) == 0);
         repeat (len) begin
            plan_random_req(mix, drain);
            drain = 0;
         end
      end
      list_image.delete();   // the run starts again from an empty list

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || !drained);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && predicted_replies.size() == 0)
         $display("** positional_list_engine_top: PASSED **");
      else
         $display("** positional_list_engine_top: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   list_req_type next_req;
   int           gap_left;
   int           burst_left;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left       <= 0;
         burst_left     <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left != 0) begin
            req_chan.valid <= 1'b0;
            gap_left       <= gap_left - 1;
         end else if (pending_reqs.size() == 0 ||
                      (pending_reqs[0].drain_first && (req_chan.valid || !drained))) begin
            req_chan.valid <= 1'b0;
         end else begin
            next_req            = pending_reqs.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.op        <= next_req.op;
            req_chan.value_in  <= next_req.value;
            req_chan.index     <= next_req.index;
            req_chan.clear_all <= next_req.clear;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   list_req_type seen_req;
   list_rsp_type want;
   rcv_type      rcv_mode;
   int           rcv_left;
   int           rcv_tick;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         drained        <= 1'b1;
         rcv_mode       <= RCV_OPEN;
         rcv_left       <= 0;
         rcv_tick       <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            seen_req.op          = req_chan.op;
            seen_req.value       = req_chan.value_in;
            seen_req.index       = req_chan.index;
            seen_req.clear       = req_chan.clear_all;
            seen_req.drain_first = 0;
            predicted_replies.push_back(apply_list_op(seen_req));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_replies.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transaction, expected none, %s %0d value %0d count %0d",
                        $time, "got status", rsp_chan.status, rsp_chan.value_out,
                        rsp_chan.count);
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_chan.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d got %0d", $time, want.status,
                           rsp_chan.status);
               end
               if (rsp_chan.value_out !== want.taken) begin
                  mismatches++;
                  $display("%0t: value_out expected %0d got %0d", $time, want.taken,
                           rsp_chan.value_out);
               end
               if (rsp_chan.count !== want.count) begin
                  mismatches++;
                  $display("%0t: count expected %0d got %0d", $time, want.count,
                           rsp_chan.count);
               end
            end
         end
         drained  <= (predicted_replies.size() == 0);
         rcv_tick <= rcv_tick + 1;
         if (rcv_left == 0) begin
            rcv_mode <= rcv_type'($urandom_range(RCV_OPEN, RCV_CHOKE));
            rcv_left <= $urandom_range(8, 64);
         end else begin
            rcv_left <= rcv_left - 1;
         end
         case (rcv_mode)
            RCV_OPEN:     rsp_chan.ready <= 1'b1;
            RCV_THROTTLE: rsp_chan.ready <= (rcv_tick % 3) != 0;
            RCV_COIN:     rsp_chan.ready <= 1'($urandom_range(0, 1));
            default:      rsp_chan.ready <= (rcv_tick % 19) == 0;   // long stalls
         endcase
      end
   end

   // ---------------------------------------------------------------- watchdog

   int idle_cycles;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("** positional_list_engine_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine_top.sv
rtl/ple_checker.sv
tb/positional_list_engine_top_test.sv
